>>> rtl/vrr_pkg.sv
package vrr_pkg;

  localparam int unsigned NumVectorsDef = 256;
  localparam int unsigned FirstVec      = 32;

  localparam logic [1:0] OP_MARK  = 2'd0;
  localparam logic [1:0] OP_TEST  = 2'd1;
  localparam logic [1:0] OP_FIND  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  typedef struct packed {
    logic cap;
    logic clr_wr;
    logic mark_wr;
    logic rd_vec;
    logic rd_run;
    logic find_init;
    logic hit_adv;
    logic run_inc;
    logic set_found;
    logic set_used;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       clr_last;
    logic       cand_ok;
    logic       run_full;
    logic       min_ok;
    logic       bit_used;
  } sts_t;

endpackage

>>> rtl/vector_range_reserver.sv
// Vector range reserver: a map of NUM_VECTORS used flags for interrupt vectors.
// Input channel (in_valid_i / in_stall_o) carries op_i, vector_i, count_i,
// min_count_i and aligned_i; a transfer happens when valid is high and stall low.
// Ops: mark vector used, test vector, find a free range from vector 32 up,
// clear the whole map. Every op returns one result on the output channel
// (out_valid_o / out_stall_i): range_start_o, range_length_o, vector_used_o.
// One item is in work at a time; the map is a single-port bit memory and each
// step costs one access. Mark writes the vector's flag, test reads it, clear
// sweeps every flag of the map, and find reads the map one bit at a time from
// vector 32 up, evaluating each bit before it reads the next.
// The scan never revisits a bit, so a find is bounded by the map size.
// After reset the block sweeps every flag of the map clear with the input
// stalled. A finished result waits in the output register while the
// receiver stalls; the next input is taken meanwhile, and its result waits
// until the pending one has been transferred.
module vector_range_reserver
  import vrr_pkg::*;
#(
  parameter int unsigned NUM_VECTORS = NumVectorsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] op_i,
  input  logic [7:0] vector_i,
  input  logic [7:0] count_i,
  input  logic [7:0] min_count_i,
  input  logic       aligned_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] range_start_o,
  output logic [7:0] range_length_o,
  output logic       vector_used_o
);

  cmd_t cmd;
  sts_t sts;

  vrr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  vrr_dpath #(
    .NUM_VECTORS (NUM_VECTORS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (op_i),
    .vector_i       (vector_i),
    .count_i        (count_i),
    .min_count_i    (min_count_i),
    .aligned_i      (aligned_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .range_start_o  (range_start_o),
    .range_length_o (range_length_o),
    .vector_used_o  (vector_used_o)
  );

endmodule

>>> rtl/vrr_ctrl.sv
module vrr_ctrl
  import vrr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_TEV    = 3'd3;
  localparam logic [2:0] S_CHECK  = 3'd4;
  localparam logic [2:0] S_EVAL   = 3'd5;
  localparam logic [2:0] S_CLRALL = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  cmd_t       cmd;

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    case (state_q)
      S_INIT: begin
        cmd.clr_wr = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.cap = 1'b1;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts_i.op)
          OP_MARK: begin
            cmd.mark_wr = 1'b1;
            state_d     = S_DONE;
          end
          OP_TEST: begin
            cmd.rd_vec = 1'b1;
            state_d    = S_TEV;
          end
          OP_FIND: begin
            cmd.find_init = 1'b1;
            state_d       = S_CHECK;
          end
          default: state_d = S_CLRALL;
        endcase
      end
      S_TEV: begin
        cmd.set_used = 1'b1;
        state_d      = S_DONE;
      end
      S_CHECK: begin
        if (!sts_i.cand_ok) begin
          state_d = S_DONE;
        end else if (sts_i.run_full) begin
          cmd.set_found = 1'b1;
          state_d       = S_DONE;
        end else begin
          cmd.rd_run = 1'b1;
          state_d    = S_EVAL;
        end
      end
      S_EVAL: begin
        state_d = S_CHECK;
        if (sts_i.bit_used) begin
          if (sts_i.min_ok) begin
            cmd.set_found = 1'b1;
            state_d       = S_DONE;
          end else begin
            cmd.hit_adv = 1'b1;
          end
        end else begin
          cmd.run_inc = 1'b1;
        end
      end
      S_CLRALL: begin
        cmd.clr_wr = 1'b1;
        if (sts_i.clr_last) state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd.out_load = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (cmd.out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !(out_valid_q && out_stall_i))
    else $error("result loaded over a pending transfer");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_EXEC))
    else $error("accepted transfer not dispatched");

  a_eval_after_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL) |-> ($past(state_q) == S_CHECK))
    else $error("scan evaluate without read");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_DONE))
    else $error("result valid outside done");

endmodule

>>> rtl/vrr_dpath.sv
module vrr_dpath
  import vrr_pkg::*;
#(
  parameter int unsigned NUM_VECTORS = NumVectorsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] op_i,
  input  logic [7:0] vector_i,
  input  logic [7:0] count_i,
  input  logic [7:0] min_count_i,
  input  logic       aligned_i,
  input  cmd_t       cmd_i,
  output sts_t       sts_o,
  output logic [7:0] range_start_o,
  output logic [7:0] range_length_o,
  output logic       vector_used_o
);

  localparam int unsigned AW = $clog2(NUM_VECTORS);
  localparam int unsigned SW = $clog2(NUM_VECTORS + 256);

  logic          mem [NUM_VECTORS];

  logic [1:0]    op_q;
  logic [7:0]    vec_q, cnt_q, minc_q;
  logic          algn_q;
  logic [SW-1:0] s_q;
  logic [7:0]    n_q;
  logic [AW-1:0] clr_ptr_q;
  logic          rdata_q;
  logic [7:0]    res_start_q, res_len_q;
  logic          res_used_q;
  logic [7:0]    out_start_q, out_len_q;
  logic          out_used_q;

  logic [SW-1:0] vec_ext, run_sum, cand_sum, s_next;
  logic          vec_ok, we, wd, re;
  logic [AW-1:0] wa, ra;

  assign vec_ext  = SW'(vec_q);
  assign vec_ok   = vec_ext < SW'(NUM_VECTORS);
  assign run_sum  = s_q + SW'(n_q);
  assign cand_sum = s_q + SW'(cnt_q);
  assign s_next   = algn_q ? cand_sum : run_sum + SW'(1);

  assign we = cmd_i.clr_wr | (cmd_i.mark_wr & vec_ok);
  assign wa = cmd_i.clr_wr ? clr_ptr_q : vec_ext[AW-1:0];
  assign wd = ~cmd_i.clr_wr;
  assign re = cmd_i.rd_run | (cmd_i.rd_vec & vec_ok);
  assign ra = cmd_i.rd_vec ? vec_ext[AW-1:0] : run_sum[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    if (re) rdata_q <= mem[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_ptr_q <= '0;
    end else if (cmd_i.clr_wr) begin
      if (sts_o.clr_last) clr_ptr_q <= '0;
      else                clr_ptr_q <= clr_ptr_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      op_q        <= op_i;
      vec_q       <= vector_i;
      cnt_q       <= count_i;
      minc_q      <= min_count_i;
      algn_q      <= aligned_i;
      res_start_q <= '0;
      res_len_q   <= '0;
      res_used_q  <= 1'b0;
    end
    if (cmd_i.find_init) begin
      s_q <= SW'(FirstVec);
      n_q <= '0;
    end
    if (cmd_i.hit_adv) begin
      s_q <= s_next;
      n_q <= '0;
    end
    if (cmd_i.run_inc) n_q <= n_q + 8'd1;
    if (cmd_i.set_found) begin
      res_start_q <= s_q[7:0];
      res_len_q   <= n_q;
    end
    if (cmd_i.set_used) res_used_q <= rdata_q & vec_ok;
    if (cmd_i.out_load) begin
      out_start_q <= res_start_q;
      out_len_q   <= res_len_q;
      out_used_q  <= res_used_q;
    end
  end

  assign sts_o.op       = op_q;
  assign sts_o.clr_last = (clr_ptr_q == AW'(NUM_VECTORS - 1));
  assign sts_o.cand_ok  = cand_sum < SW'(NUM_VECTORS);
  assign sts_o.run_full = (n_q == cnt_q);
  assign sts_o.min_ok   = (n_q >= minc_q);
  assign sts_o.bit_used = rdata_q;

  assign range_start_o  = out_start_q;
  assign range_length_o = out_len_q;
  assign vector_used_o  = out_used_q;

endmodule
